[hw/rtl/bas_pkg.sv]
// bas_pkg: shared types, opcodes and constants of the bitmap allocator scan core
// used by bas_ctrl, bas_dp and the top level in hw/rtl; depends on nothing

package bas_pkg;

    // fixed field widths of the request and result items
    localparam int OP_W        = 3;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int INDEX_LIMIT = 1024;

    // defaults for the top level parameters
    localparam int DEF_MAX_BITS  = 1024;
    localparam int DEF_WORD_BITS = 32;

    // active bit count after reset
    localparam logic [CNT_W-1:0] ACTIVE_RESET = 11'd1024;

    // request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_SET       = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_TEST      = 3'd2,
        OP_FIND_CLR  = 3'd3,
        OP_FIND_SET  = 3'd4,
        OP_CLEAR_ALL = 3'd5,
        OP_SET_ALL   = 3'd6
    } t_opcode;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // latch a new request, restart counters and accumulators
        logic rd;        // read the next active word for the scan
        logic sweep_wr;  // write the fill pattern to the next word
        logic fill;      // fill pattern bit for sweeps
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic rd_end;      // no active word left to read
        logic dv;          // a read word is being processed this cycle
        logic sweep_last;  // the sweep write this cycle is the last word
        logic op_sweep;    // latched request is clear all or set all
        logic fill_one;    // latched request is set all
        logic out_free;    // output register can take a result this cycle
    } t_dp_sts;

endpackage

[hw/rtl/bas_ram.sv]
// bas_ram: generic single write port, single read port ram with registered read
// no dependencies

module bas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bas_ctrl.sv]
// bas_ctrl: controller state machine of the bitmap allocator scan core
// depends on bas_pkg for the command and status structs

module bas_ctrl
    import bas_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_START = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                // clearing pass over the store after reset
                o_cmd.sweep_wr = 1'b1;
                o_cmd.fill     = 1'b0;
                if (i_sts.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                n_state = i_sts.op_sweep ? ST_SWEEP : ST_SCAN;
            end
            ST_SCAN: begin
                // issue reads until the active words run out, then drain
                o_cmd.rd = !i_sts.rd_end;
                if (i_sts.rd_end && !i_sts.dv) n_state = ST_FIN;
            end
            ST_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                o_cmd.fill     = i_sts.fill_one;
                if (i_sts.sweep_last) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

[hw/rtl/bas_dp.sv]
// bas_dp: datapath of the bitmap allocator scan core: config register, flag store,
// word scan with accumulators and the output register; depends on bas_pkg, bas_ram

module bas_dp
    import bas_pkg::*;
#(
    parameter int MAX_BITS  = DEF_MAX_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [IDX_W-1:0] i_bit_index,
    input  logic             i_out_ready,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    output logic             o_found,
    output logic [IDX_W-1:0] o_found_index,
    output logic             o_all_clear,
    output logic             o_all_set
);

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int BASE_W    = $clog2(INDEX_LIMIT + WORD_BITS);
    localparam int CMP_W     = BASE_W + 1;
    localparam int LIM       = (MAX_BITS < INDEX_LIMIT) ? MAX_BITS : INDEX_LIMIT;

    // config register and effective count
    logic [CNT_W-1:0] r_cfg_bits;
    logic [CNT_W-1:0] w_count;
    logic [CMP_W-1:0] w_count_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bits <= ACTIVE_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg_bits <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_cfg_bits == '0) begin
            w_count = CNT_W'(1);
        end else if (r_cfg_bits > CNT_W'(LIM)) begin
            w_count = CNT_W'(LIM);
        end else begin
            w_count = r_cfg_bits;
        end
    end

    assign w_count_x = CMP_W'(w_count);

    // latched request
    logic [OP_W-1:0]  r_op;
    logic [IDX_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_idx <= i_bit_index;
        end
    end

    // read side counters
    logic [AW-1:0]     r_rd_addr;
    logic [BASE_W-1:0] r_rd_base;
    logic              r_dv;
    logic [AW-1:0]     r_dp_addr;
    logic [BASE_W-1:0] r_dp_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_rd_base <= '0;
            r_dv      <= 1'b0;
        end else begin
            r_dv <= i_cmd.rd;
            if (i_cmd.load) begin
                r_rd_addr <= '0;
                r_rd_base <= '0;
            end else if (i_cmd.rd || i_cmd.sweep_wr) begin
                r_rd_addr <= r_rd_addr + AW'(1);
                r_rd_base <= r_rd_base + BASE_W'(WORD_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_dp_addr <= r_rd_addr;
            r_dp_base <= r_rd_base;
        end
    end

    // decoded request
    logic w_is_set;
    logic w_is_clr;
    logic w_is_test;

    assign w_is_set  = (r_op == OP_SET);
    assign w_is_clr  = (r_op == OP_CLEAR);
    assign w_is_test = (r_op == OP_TEST);

    // word processing for the word returned by the store
    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_new;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_set_bits;
    logic [WORD_BITS-1:0] w_clr_bits;
    logic [CMP_W-1:0]     w_base_x;
    logic [CMP_W-1:0]     w_rem;
    logic [CMP_W-1:0]     w_idx_x;
    logic [CMP_W-1:0]     w_rel;
    logic [OFF_W-1:0]     w_off;
    logic                 w_hit;
    logic                 w_test;
    logic [OFF_W-1:0]     w_fs_off;
    logic [OFF_W-1:0]     w_fc_off;

    assign w_base_x = CMP_W'(r_dp_base);
    assign w_rem    = w_count_x - w_base_x;
    assign w_idx_x  = CMP_W'(r_idx);
    assign w_rel    = w_idx_x - w_base_x;
    assign w_off    = w_rel[OFF_W-1:0];
    assign w_hit    = r_dv && (w_idx_x < w_count_x) && (w_idx_x >= w_base_x)
                      && (w_rel < CMP_W'(WORD_BITS));

    // modified word, active mask and tested bit
    always_comb begin
        w_test = 1'b0;
        for (int b = 0; b < WORD_BITS; b++) begin
            w_mask[b] = (CMP_W'(b) < w_rem);
            if (w_hit && (w_off == OFF_W'(b))) begin
                w_new[b] = w_is_set ? 1'b1 : (w_is_clr ? 1'b0 : w_word[b]);
                w_test   = w_test | w_word[b];
            end else begin
                w_new[b] = w_word[b];
            end
        end
    end

    assign w_set_bits = w_new & w_mask;
    assign w_clr_bits = ~w_new & w_mask;

    // lowest set and lowest clear active bit in the word
    always_comb begin
        w_fs_off = '0;
        w_fc_off = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_set_bits[b]) w_fs_off = OFF_W'(b);
            if (w_clr_bits[b]) w_fc_off = OFF_W'(b);
        end
    end

    // flag store
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;

    always_comb begin
        if (i_cmd.sweep_wr) begin
            w_we    = 1'b1;
            w_waddr = r_rd_addr;
            w_wdata = {WORD_BITS{i_cmd.fill}};
        end else begin
            w_we    = w_hit && (w_is_set || w_is_clr);
            w_waddr = r_dp_addr;
            w_wdata = w_new;
        end
    end

    bas_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_rd_addr),
        .o_rdata (w_word)
    );

    // scan accumulators
    logic             r_any_set;
    logic             r_any_clr;
    logic             r_test;
    logic             r_fs_found;
    logic             r_fc_found;
    logic [IDX_W-1:0] r_fs_idx;
    logic [IDX_W-1:0] r_fc_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_any_set  <= 1'b0;
            r_any_clr  <= 1'b0;
            r_test     <= 1'b0;
            r_fs_found <= 1'b0;
            r_fc_found <= 1'b0;
            r_fs_idx   <= '0;
            r_fc_idx   <= '0;
        end else if (r_dv) begin
            r_any_set <= r_any_set | (|w_set_bits);
            r_any_clr <= r_any_clr | (|w_clr_bits);
            r_test    <= r_test | w_test;
            if (!r_fs_found && (|w_set_bits)) begin
                r_fs_found <= 1'b1;
                r_fs_idx   <= IDX_W'(r_dp_base + BASE_W'(w_fs_off));
            end
            if (!r_fc_found && (|w_clr_bits)) begin
                r_fc_found <= 1'b1;
                r_fc_idx   <= IDX_W'(r_dp_base + BASE_W'(w_fc_off));
            end
        end
    end

    // result selection
    logic             w_res_found;
    logic [IDX_W-1:0] w_res_idx;
    logic             w_res_clear;
    logic             w_res_set;

    always_comb begin
        w_res_found = 1'b0;
        w_res_idx   = '0;
        w_res_clear = !r_any_set;
        w_res_set   = !r_any_clr;
        case (r_op)
            OP_TEST: begin
                w_res_found = r_test;
            end
            OP_FIND_CLR: begin
                w_res_found = r_fc_found;
                w_res_idx   = r_fc_idx;
            end
            OP_FIND_SET: begin
                w_res_found = r_fs_found;
                w_res_idx   = r_fs_idx;
            end
            OP_CLEAR_ALL: begin
                w_res_clear = 1'b1;
                w_res_set   = 1'b0;
            end
            OP_SET_ALL: begin
                w_res_clear = 1'b0;
                w_res_set   = 1'b1;
            end
            default: begin
                w_res_found = 1'b0;
            end
        endcase
    end

    // output register
    logic             r_out_valid;
    logic             r_out_found;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_clear;
    logic             r_out_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= w_res_found;
            r_out_idx   <= w_res_idx;
            r_out_clear <= w_res_clear;
            r_out_set   <= w_res_set;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_found_index = r_out_idx;
    assign o_all_clear   = r_out_clear;
    assign o_all_set     = r_out_set;

    // status back to the controller
    assign o_sts.rd_end     = (CMP_W'(r_rd_base) >= w_count_x);
    assign o_sts.dv         = r_dv;
    assign o_sts.sweep_last = (r_rd_addr == AW'(NUM_WORDS - 1));
    assign o_sts.op_sweep   = (r_op == OP_CLEAR_ALL) || (r_op == OP_SET_ALL);
    assign o_sts.fill_one   = (r_op == OP_SET_ALL);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

[hw/rtl/bitmap_allocator_scan_core.sv]
// bitmap_allocator_scan_core: bitmap flag store with set, clear, test, find and fill
// depends on bas_pkg, bas_ctrl, bas_dp (which holds bas_ram)
//
// usage
//   requests come in on the s_axis group: the opcode on tuser, the bit index on tdata.
//   each request gives exactly one result item on the m_axis group: found on tuser,
//   found index and the all clear / all set flags on tdata.
//   the active bit count is written through i_cfg_wr_en / i_cfg_wr_data while idle.
// throughput
//   one request at a time. set, clear, test, find and unused opcodes scan the active
//   words of the store one per cycle through its registered read port.
//   clear all and set all write every stored word, one per cycle.
// reset
//   the active count returns to 1024 and the store is cleared by a pass over every
//   stored word, during which s_axis_tready stays low.
// stalls
//   the result waits in an output register; the next request is taken meanwhile,
//   and its result is held back until the previous one has been taken.

module bitmap_allocator_scan_core
    import bas_pkg::*;
#(
    parameter int MAX_BITS  = DEF_MAX_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: active bit count
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    // request items
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [9:0] bit_index, [15:10] zero
    input  logic [2:0]       s_axis_tuser,   // [2:0] opcode
    // result items
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [9:0] found_index, [10] all_clear,
                                             // [11] all_set, [15:12] zero
    output logic             m_axis_tuser    // [0] found
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic             w_found;
    logic [IDX_W-1:0] w_found_index;
    logic             w_all_clear;
    logic             w_all_set;

    // controller
    bas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    bas_dp #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_opcode      (s_axis_tuser),
        .i_bit_index   (s_axis_tdata[IDX_W-1:0]),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_found       (w_found),
        .o_found_index (w_found_index),
        .o_all_clear   (w_all_clear),
        .o_all_set     (w_all_set)
    );

    // result packing
    assign m_axis_tdata = {4'b0000, w_all_set, w_all_clear, w_found_index};
    assign m_axis_tuser = w_found;

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while the previous one is in work");

    a_no_scan_during_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.rd && w_cmd.sweep_wr))
        else $error("scan read issued during a sweep");

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over an untaken result");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.out_load))
        else $error("result valid without a result load");

endmodule

[tb/tb_bitmap_allocator_scan_core.sv]
// testbench for bitmap_allocator_scan_core: directed table plus random phases over
// several active bit counts; depends on bas_pkg and the core rtl only
`timescale 1ns / 1ps

module tb_bitmap_allocator_scan_core;
    import bas_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int NUM_FLAGS     = DEF_MAX_BITS;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 155;

    // one result item, split into its fields
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             all_clear;
        logic             all_set;
    } t_result;

    // one row of the directed table: a count write or a request
    typedef struct {
        bit               is_cfg;
        logic [CNT_W-1:0] cfg_value;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        bit               typed;
        t_result          want;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CNT_W-1:0] i_cfg_wr_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [15:0]      s_axis_tdata;   // [9:0] bit_index, [15:10] zero
    logic [2:0]       s_axis_tuser;   // [2:0] opcode
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [15:0]      m_axis_tdata;   // [9:0] found_index, [10] all_clear, [11] all_set
    logic             m_axis_tuser;   // [0] found

    // shadow of the flag store and the active count
    bit [NUM_FLAGS-1:0] flag_map;
    int                 active_count;
    t_result            pending_results[$];

    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  finds_hit;
    int  cycle_count;
    bit  no_idle;
    int  hold_asked;
    int  hold_given;
    int  hold_left;
    int  rx_wait;

    t_dir_row dir_rows[24];

    bitmap_allocator_scan_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // written count saturates into 1..1024
    function automatic int clamp_count(logic [CNT_W-1:0] value);
        if (value == 0) return 1;
        if (value > INDEX_LIMIT) return INDEX_LIMIT;
        return int'(value);
    endfunction

    // lowest active flag equal to value
    function automatic bit lowest_match(bit value, output int pos);
        pos = 0;
        for (int i = 0; i < active_count; i++) begin
            if (flag_map[i] == value) begin
                pos = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // apply one request to the shadow store and work out its result
    function automatic t_result predict_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
        t_result res;
        int      pos;
        bit      in_range;
        res      = '0;
        in_range = int'(idx) < active_count;
        case (op)
            OP_SET: begin
                if (in_range) flag_map[idx] = 1'b1;
            end
            OP_CLEAR: begin
                if (in_range) flag_map[idx] = 1'b0;
            end
            OP_TEST: begin
                if (in_range) res.found = flag_map[idx];
            end
            OP_FIND_CLR, OP_FIND_SET: begin
                if (lowest_match(op == OP_FIND_SET, pos)) begin
                    res.found       = 1'b1;
                    res.found_index = pos[IDX_W-1:0];
                end
            end
            OP_CLEAR_ALL: flag_map = '0;
            OP_SET_ALL:   flag_map = '1;
            default: ;
        endcase
        res.all_clear = !lowest_match(1'b1, pos);
        res.all_set   = !lowest_match(1'b0, pos);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
    endtask

    // compare one accepted result item with the oldest expectation
    task automatic check_result();
        t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("result item with none pending, tdata", int'(m_axis_tdata), 0);
        end else begin
            want = pending_results.pop_front();
            if (m_axis_tuser !== want.found)
                report_mismatch("found", int'(m_axis_tuser), int'(want.found));
            if (m_axis_tdata[9:0] !== want.found_index)
                report_mismatch("found_index", int'(m_axis_tdata[9:0]), int'(want.found_index));
            if (m_axis_tdata[10] !== want.all_clear)
                report_mismatch("all_clear", int'(m_axis_tdata[10]), int'(want.all_clear));
            if (m_axis_tdata[11] !== want.all_set)
                report_mismatch("all_set", int'(m_axis_tdata[11]), int'(want.all_set));
            if (want.found) finds_hit++;
        end
    endtask

    // result side: random stalls per item and a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
                rx_wait = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (hold_asked != hold_given) begin
                hold_left  = LONG_HOLD;
                hold_given = hold_asked;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one request item after a random gap, record its result once taken
    task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                bit typed, t_result want);
        int      gap;
        t_result pred;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, idx};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_request(op, idx);
        pending_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // stop offering and wait for every pending result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the active count while the core is idle
    task automatic write_active_count(logic [CNT_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        active_count = clamp_count(value);
    endtask

    function automatic t_dir_row req_row(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
        t_dir_row row;
        row        = '{default: '0};
        row.op     = op;
        row.idx    = idx;
        return row;
    endfunction

    function automatic t_dir_row typed_row(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                           t_result want);
        t_dir_row row;
        row       = req_row(op, idx);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(logic [CNT_W-1:0] value);
        t_dir_row row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cfg_value = value;
        return row;
    endfunction

    // random request mixed per phase; most indices fall inside the active count
    task automatic random_request(int set_share);
        int               r;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 3)       op = OP_CLEAR_ALL;
        else if (r < 6)  op = OP_SET_ALL;
        else if (r < 8)  op = OP_UNUSED;
        else if (r < 20) op = OP_FIND_CLR;
        else if (r < 32) op = OP_FIND_SET;
        else if (r < 42) op = OP_TEST;
        else             op = ($urandom_range(0, 99) < set_share) ? OP_SET : OP_CLEAR;
        if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, active_count - 1));
        else                            idx = IDX_W'($urandom_range(0, NUM_FLAGS - 1));
        send_request(op, idx, 1'b0, '0);
    endtask

    initial begin
        logic [CNT_W-1:0] phase_counts[NUM_PHASES];
        int               set_share;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        flag_map      = '0;
        active_count  = clamp_count(ACTIVE_RESET);
        mismatches    = 0;
        items_sent    = 0;
        results_seen  = 0;
        finds_hit     = 0;
        cycle_count   = 0;
        no_idle       = 1'b0;
        hold_asked    = 0;
        hold_given    = 0;
        hold_left     = 0;
        rx_wait       = 0;

        // directed rows: fields {found, found_index, all_clear, all_set}
        dir_rows[0]  = typed_row(OP_TEST, 10'd0, '{1'b0, 10'd0, 1'b1, 1'b0});
        dir_rows[1]  = typed_row(OP_FIND_SET, 10'd0, '{1'b0, 10'd0, 1'b1, 1'b0});
        dir_rows[2]  = typed_row(OP_FIND_CLR, 10'd1023, '{1'b1, 10'd0, 1'b1, 1'b0});
        dir_rows[3]  = req_row(OP_SET, 10'd1023);
        dir_rows[4]  = req_row(OP_TEST, 10'd1023);
        dir_rows[5]  = req_row(OP_FIND_SET, 10'd0);
        dir_rows[6]  = typed_row(OP_SET_ALL, 10'd0, '{1'b0, 10'd0, 1'b0, 1'b1});
        dir_rows[7]  = typed_row(OP_FIND_CLR, 10'd0, '{1'b0, 10'd0, 1'b0, 1'b1});
        dir_rows[8]  = req_row(OP_CLEAR, 10'd1023);
        dir_rows[9]  = req_row(OP_FIND_CLR, 10'd0);
        dir_rows[10] = req_row(OP_UNUSED, 10'd1023);
        dir_rows[11] = typed_row(OP_CLEAR_ALL, 10'd1023, '{1'b0, 10'd0, 1'b1, 1'b0});
        // zero count acts as one, so index 1 is out of range
        dir_rows[12] = cfg_row(11'd0);
        dir_rows[13] = req_row(OP_SET, 10'd1);
        dir_rows[14] = typed_row(OP_TEST, 10'd1, '{1'b0, 10'd0, 1'b1, 1'b0});
        dir_rows[15] = req_row(OP_SET, 10'd0);
        dir_rows[16] = typed_row(OP_FIND_CLR, 10'd0, '{1'b0, 10'd0, 1'b0, 1'b1});
        // oversize count saturates to the full store
        dir_rows[17] = cfg_row(11'd2047);
        dir_rows[18] = req_row(OP_FIND_CLR, 10'd0);
        // count ending one flag into the second word
        dir_rows[19] = cfg_row(11'd33);
        dir_rows[20] = typed_row(OP_SET_ALL, 10'd0, '{1'b0, 10'd0, 1'b0, 1'b1});
        dir_rows[21] = req_row(OP_CLEAR, 10'd32);
        dir_rows[22] = req_row(OP_FIND_CLR, 10'd0);
        dir_rows[23] = typed_row(OP_TEST, 10'd33, '{1'b0, 10'd0, 1'b0, 1'b0});

        // hold reset, then release it
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_active_count(dir_rows[i].cfg_value);
            else
                send_request(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].typed,
                             dir_rows[i].want);
        end

        // random phases, each behind a count write; the drain before it pauses the sender
        phase_counts = '{11'd1024, 11'd1, 11'd33, 11'd2047, 11'd0, 11'd32, 11'd1023,
                         11'(50 + $urandom_range(0, 972))};
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_active_count(phase_counts[phase]);
            no_idle   = (phase == 2);
            set_share = $urandom_range(20, 80);
            // long receiver hold-off while requests keep coming
            if (phase == 0) hold_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++) random_request(set_share);
        end
        no_idle = 1'b0;

        wait_drained();
        $display("covered %0d request items and %0d result items over %0d count settings",
                 items_sent, results_seen, NUM_PHASES + 4);
        $display("finds and tests reporting found: %0d, mismatches: %0d", finds_hit, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/bas_pkg.sv
hw/rtl/bas_ram.sv
hw/rtl/bas_ctrl.sv
hw/rtl/bas_dp.sv
hw/rtl/bitmap_allocator_scan_core.sv
tb/tb_bitmap_allocator_scan_core.sv
